/* rtl/core/rcsp_pkg.sv */
// rcsp_pkg: shared widths, register indexes, reset values and stage types
// for the rc steering pulse integrator. No dependencies.

package rcsp_pkg;

	// field and state widths
	localparam int STAMP_W = 32;
	localparam int ACC_W   = 36;
	localparam int CNT_W   = 4;
	localparam int SP_W    = 21;
	localparam int LIM_W   = 20;
	localparam int DB_W    = 16;
	localparam int WIN_W   = 20;
	localparam int EXC_W   = 20;
	localparam int TPS_W   = 16;

	// parameter defaults
	localparam int CAL_PULSES_DEF     = 10;
	localparam int TICKS_PER_STEP_DEF = 130;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS   = 2'd2;

	localparam logic [LIM_W-1:0] LIMIT_RST    = 20'd10000;
	localparam logic [DB_W-1:0]  DEADBAND_RST = 16'd4000;
	localparam logic [WIN_W-1:0] WINDOW_RST   = 20'd50000;

	// measured pulse width leaving the front stage
	typedef struct packed {
		logic                      valid;
		logic signed [STAMP_W-1:0] width;
	} rcsp_meas_t;

	// setpoint increment leaving the step pipeline
	typedef struct packed {
		logic             valid;
		logic             neg;
		logic [EXC_W-1:0] mag;
	} rcsp_step_t;

	// centre divider status
	typedef struct packed {
		logic                      busy;
		logic signed [STAMP_W-1:0] centre;
	} rcsp_centre_t;

endpackage

/* rtl/core/rcsp_in_if.sv */
// rcsp_in_if: capture event channel (valid/ready plus event fields).
// Depends on rcsp_pkg for field widths.

interface rcsp_in_if
	import rcsp_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               edge_high;
	logic [STAMP_W-1:0] stamp;
	logic               auto_mode;

	modport source (output valid, output edge_high, output stamp, output auto_mode,
		input ready);
	modport sink (input valid, input edge_high, input stamp, input auto_mode,
		output ready);
endinterface

/* rtl/core/rcsp_out_if.sv */
// rcsp_out_if: steering setpoint result channel (valid/ready plus setpoint).
// Depends on rcsp_pkg for the setpoint width.

interface rcsp_out_if
	import rcsp_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic signed [SP_W-1:0] steer_setpoint;

	modport source (output valid, output steer_setpoint, input ready);
	modport sink (input valid, input steer_setpoint, output ready);
endinterface

/* rtl/core/rc_steering_pulse_integrator.sv */
// rc_steering_pulse_integrator: one capture event per cycle while s1 can advance and
// no centre divide runs; a setpoint beat passes s1..s4 and the result reg in order.
// The last calibration pulse starts a centre divide (reciprocal multiply
// and correction), during which no event is taken.
// Async active-low reset: registers to reset values, calibration restarts.
// Depends on rcsp_pkg, rcsp_in_if, rcsp_out_if, rcsp_front/cdiv/step/integ.

module rc_steering_pulse_integrator
	import rcsp_pkg::*;
#(
	parameter int CAL_PULSES     = CAL_PULSES_DEF,
	parameter int TICKS_PER_STEP = TICKS_PER_STEP_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rcsp_in_if.sink               evt,
	rcsp_out_if.source            res
);
	logic [LIM_W-1:0] limit_q;
	logic [DB_W-1:0]  deadband_q;
	logic [WIN_W-1:0] window_q;

	logic                    div_start;
	logic signed [ACC_W-1:0] div_sum;
	rcsp_centre_t            centre;
	rcsp_meas_t              meas;
	rcsp_step_t              step;
	logic                    take;
	logic                    free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= LIMIT_RST;
			deadband_q <= DEADBAND_RST;
			window_q   <= WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SETPOINT_LIMIT: limit_q    <= cfg_data[LIM_W-1:0];
				REG_DEADBAND_TICKS: deadband_q <= cfg_data[DB_W-1:0];
				REG_WINDOW_TICKS:   window_q   <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	rcsp_front #(.CAL_PULSES(CAL_PULSES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.take      (take),
		.div_busy  (centre.busy),
		.div_start (div_start),
		.div_sum   (div_sum),
		.meas      (meas)
	);

	rcsp_cdiv #(.CAL_PULSES(CAL_PULSES)) u_cdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_sum),
		.status   (centre)
	);

	rcsp_step #(.TICKS_PER_STEP(TICKS_PER_STEP)) u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.meas           (meas),
		.centre         (centre.centre),
		.deadband_ticks (deadband_q),
		.window_ticks   (window_q),
		.free           (free),
		.take           (take),
		.step           (step)
	);

	rcsp_integ u_integ (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.setpoint_limit (limit_q),
		.free           (free),
		.res            (res)
	);
endmodule

/* rtl/core/rcsp_cdiv.sv */
// rcsp_cdiv: divides the calibration sum by the pulse count to give the centre
// width, by reciprocal multiply and one correction step. Depends on rcsp_pkg.

module rcsp_cdiv
	import rcsp_pkg::*;
#(
	parameter int CAL_PULSES = CAL_PULSES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] dividend,
	output rcsp_centre_t            status
);
	localparam int MagW = ACC_W - 1;
	localparam int LoW  = 18;
	localparam int HiW  = MagW - LoW;
	localparam int RecW = MagW + 1;
	localparam int PpW  = 2 * LoW;
	localparam int SumW = 2 * MagW + 1;
	localparam int QdW  = MagW + CNT_W;
	// floor(2^MagW / count): the estimate is low by at most one
	localparam logic [RecW-1:0]  Recip   = RecW'((64'd1 << MagW) / CAL_PULSES);
	localparam logic [LoW-1:0]   RecLo   = Recip[LoW-1:0];
	localparam logic [LoW-1:0]   RecHi   = Recip[RecW-1:LoW];
	localparam logic [CNT_W-1:0] Divisor = CNT_W'(CAL_PULSES);

	localparam logic [1:0] PhMul = 2'd0;
	localparam logic [1:0] PhEst = 2'd1;
	localparam logic [1:0] PhFix = 2'd2;

	logic                      busy_q;
	logic [1:0]                ph_q;
	logic                      neg_q;
	logic [MagW-1:0]           mag_q;
	logic [PpW-1:0]            ll_q, lh_q, hl_q, hh_q;
	logic [MagW-1:0]           qe_q;
	logic signed [STAMP_W-1:0] centre_q;

	logic [MagW-1:0] dividend_mag;
	logic [SumW-1:0] prod_sum;
	logic [QdW-1:0]  qd;
	logic [MagW-1:0] rem;
	logic [MagW-1:0] quo;

	assign dividend_mag = dividend[ACC_W-1] ? MagW'(-dividend) : MagW'(dividend);

	always_comb begin
		prod_sum = SumW'(ll_q) + (SumW'(lh_q) << LoW) + (SumW'(hl_q) << LoW)
			+ (SumW'(hh_q) << (2 * LoW));
		qd  = QdW'(qe_q) * QdW'(Divisor);
		rem = mag_q - qd[MagW-1:0];
		quo = qe_q + MagW'(rem >= MagW'(Divisor));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ph_q     <= PhMul;
			centre_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			ph_q   <= PhMul;
		end else if (busy_q) begin
			case (ph_q)
				PhMul: ph_q <= PhEst;
				PhEst: ph_q <= PhFix;
				PhFix: begin
					busy_q   <= 1'b0;
					ph_q     <= PhMul;
					centre_q <= neg_q ? -signed'(quo[STAMP_W-1:0])
						: signed'(quo[STAMP_W-1:0]);
				end
				default: ph_q <= PhMul;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[ACC_W-1];
			mag_q <= dividend_mag;
		end
		if (busy_q && ph_q == PhMul) begin
			ll_q <= PpW'(mag_q[LoW-1:0]) * PpW'(RecLo);
			lh_q <= PpW'(mag_q[LoW-1:0]) * PpW'(RecHi);
			hl_q <= PpW'(mag_q[MagW-1:LoW]) * PpW'(RecLo);
			hh_q <= PpW'(mag_q[MagW-1:LoW]) * PpW'(RecHi);
		end
		if (busy_q && ph_q == PhEst)
			qe_q <= prod_sum[SumW-2:MagW];
	end

	assign status.busy   = busy_q;
	assign status.centre = centre_q;
endmodule

/* rtl/core/rcsp_front.sv */
// rcsp_front: event decode, rise stamp, first-fall discard, calibration sum
// and the s1 width register. Depends on rcsp_pkg and rcsp_in_if.

module rcsp_front
	import rcsp_pkg::*;
#(
	parameter int CAL_PULSES = CAL_PULSES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	rcsp_in_if.sink                 evt,
	input  logic                    take,
	input  logic                    div_busy,
	output logic                    div_start,
	output logic signed [ACC_W-1:0] div_sum,
	output rcsp_meas_t              meas
);
	localparam logic [CNT_W-1:0] CalDone = CNT_W'(CAL_PULSES);
	localparam logic [CNT_W-1:0] CalLast = CNT_W'(CAL_PULSES - 1);

	logic [STAMP_W-1:0]        rise_stamp_q;
	logic                      first_fall_q;
	logic [CNT_W-1:0]          calib_cnt_q;
	logic signed [ACC_W-1:0]   sum_q;
	logic                      valid_s1;
	logic signed [STAMP_W-1:0] width_s1;

	logic               en_s1;
	logic               accept;
	logic               fall;
	logic               calibrating;
	logic [STAMP_W-1:0] width;

	assign en_s1     = !valid_s1 || take;
	assign evt.ready = en_s1 && !div_busy;
	assign accept    = evt.valid && evt.ready && !evt.auto_mode;
	assign fall      = accept && !evt.edge_high && !first_fall_q;
	assign calibrating = (calib_cnt_q != CalDone);
	// wraps mod 2^32, read as two's complement
	assign width     = evt.stamp - rise_stamp_q;
	assign div_sum   = sum_q + {{(ACC_W-STAMP_W){width[STAMP_W-1]}}, width};
	assign div_start = fall && calibrating && (calib_cnt_q == CalLast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_stamp_q <= '0;
			first_fall_q <= 1'b1;
			calib_cnt_q  <= '0;
			sum_q        <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (accept && evt.edge_high)
				rise_stamp_q <= evt.stamp;
			if (accept && !evt.edge_high && first_fall_q)
				first_fall_q <= 1'b0;
			if (fall && calibrating) begin
				calib_cnt_q <= calib_cnt_q + 1'b1;
				sum_q       <= div_sum;
			end
			if (en_s1)
				valid_s1 <= fall && !calibrating;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1)
			width_s1 <= signed'(width);
	end

	assign meas.valid = valid_s1;
	assign meas.width = width_s1;
endmodule

/* rtl/core/rcsp_step.sv */
// rcsp_step: offset against centre, window and deadband tests, and the
// excess divided by the tick count (s2..s4). Depends on rcsp_pkg.

module rcsp_step
	import rcsp_pkg::*;
#(
	parameter int TICKS_PER_STEP = TICKS_PER_STEP_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rcsp_meas_t                meas,
	input  logic signed [STAMP_W-1:0] centre,
	input  logic [DB_W-1:0]           deadband_ticks,
	input  logic [WIN_W-1:0]          window_ticks,
	input  logic                      free,
	output logic                      take,
	output rcsp_step_t                step
);
	localparam int OffW   = STAMP_W + 1;
	localparam int RecipW = EXC_W + 1;
	localparam int ProdW  = EXC_W + RecipW;
	localparam int QdW    = EXC_W + TPS_W;
	// floor(2^EXC_W / ticks): the estimate is low by at most one
	localparam logic [RecipW-1:0] Recip  = RecipW'((64'd1 << EXC_W) / TICKS_PER_STEP);
	localparam logic [TPS_W-1:0]  Ticks  = TPS_W'(TICKS_PER_STEP);

	logic             valid_s2, valid_s3, valid_s4;
	logic             neg_s2, neg_s3, neg_s4;
	logic [EXC_W-1:0] x_s2, x_s3;
	logic [EXC_W-1:0] q_s3;
	logic [EXC_W-1:0] mag_s4;
	logic             en_s2, en_s3, en_s4;

	logic signed [OffW-1:0] offset;
	logic [OffW-1:0]        off_mag;
	logic                   pass;
	logic [ProdW-1:0]       prod;
	logic [QdW-1:0]         qd;
	logic [QdW-1:0]         rem;
	logic                   bump;

	assign en_s4 = !valid_s4 || free;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign take  = en_s2;

	always_comb begin
		offset  = {meas.width[STAMP_W-1], meas.width} - {centre[STAMP_W-1], centre};
		off_mag = offset[OffW-1] ? OffW'(-offset) : OffW'(offset);
		// magnitude equal to the deadband stays inside it
		pass    = (off_mag <= OffW'(window_ticks)) && (off_mag > OffW'(deadband_ticks));
		prod    = ProdW'(x_s2) * ProdW'(Recip);
		qd      = QdW'(q_s3) * QdW'(Ticks);
		rem     = QdW'(x_s3) - qd;
		bump    = (rem >= QdW'(Ticks));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s2)
				valid_s2 <= meas.valid && pass;
			if (en_s3)
				valid_s3 <= valid_s2;
			if (en_s4)
				valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			neg_s2 <= offset[OffW-1];
			x_s2   <= off_mag[EXC_W-1:0] - EXC_W'(deadband_ticks);
		end
		if (en_s3) begin
			neg_s3 <= neg_s2;
			x_s3   <= x_s2;
			q_s3   <= prod[ProdW-2:EXC_W];
		end
		if (en_s4) begin
			neg_s4 <= neg_s3;
			mag_s4 <= q_s3 + EXC_W'(bump);
		end
	end

	assign step.valid = valid_s4;
	assign step.neg   = neg_s4;
	assign step.mag   = mag_s4;
endmodule

/* rtl/core/rcsp_integ.sv */
// rcsp_integ: running setpoint accumulate, saturation and the result
// register. Depends on rcsp_pkg and rcsp_out_if.

module rcsp_integ
	import rcsp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  rcsp_step_t       step,
	input  logic [LIM_W-1:0] setpoint_limit,
	output logic             free,
	rcsp_out_if.source       res
);
	localparam int SumW = SP_W + 1;

	logic                   valid_q;
	logic signed [SP_W-1:0] setpoint_q;

	logic signed [SumW-1:0] incr;
	logic signed [SumW-1:0] sum;
	logic signed [SumW-1:0] lim;
	logic signed [SumW-1:0] clamped;

	assign free = !valid_q || res.ready;

	always_comb begin
		incr = step.neg ? -signed'(SumW'(step.mag)) : signed'(SumW'(step.mag));
		sum  = {setpoint_q[SP_W-1], setpoint_q} + incr;
		lim  = signed'(SumW'(setpoint_limit));
		if (sum > lim)
			clamped = lim;
		else if (sum < -lim)
			clamped = -lim;
		else
			clamped = sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			setpoint_q <= '0;
		end else if (free) begin
			valid_q <= step.valid;
			if (step.valid)
				setpoint_q <= clamped[SP_W-1:0];
		end
	end

	assign res.valid          = valid_q;
	assign res.steer_setpoint = setpoint_q;
endmodule

/* rtl/core/rcsp_chk.sv */
// rcsp_chk: port-level checks for the steering integrator, bound to the
// top level below. Depends on rcsp_pkg.

module rcsp_chk
	import rcsp_pkg::*;
#(
	parameter int CAL_PULSES = CAL_PULSES_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_we,
	input logic [CFG_IDX_W-1:0]   cfg_idx,
	input logic [CFG_DATA_W-1:0]  cfg_data,
	input logic                   evt_valid,
	input logic                   evt_ready,
	input logic                   evt_edge_high,
	input logic                   evt_auto_mode,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic signed [SP_W-1:0] res_steer_setpoint
);
	localparam int FallW = CNT_W + 1;
	localparam logic [FallW-1:0] FallSat  = '1;
	localparam logic [FallW-1:0] FallNeed = FallW'(CAL_PULSES + 1);

	logic [LIM_W-1:0] limit_q;
	logic [FallW-1:0] falls_q;

	// shadow of the saturation bound and a saturating count of accepted manual falls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
			falls_q <= '0;
		end else begin
			if (cfg_we && cfg_idx == REG_SETPOINT_LIMIT)
				limit_q <= cfg_data[LIM_W-1:0];
			if (evt_valid && evt_ready && !evt_auto_mode && !evt_edge_high
				&& falls_q != FallSat)
				falls_q <= falls_q + 1'b1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (signed'({res_steer_setpoint[SP_W-1], res_steer_setpoint})
			<= signed'({2'b00, limit_q})
			&& signed'({res_steer_setpoint[SP_W-1], res_steer_setpoint})
			>= -signed'({2'b00, limit_q})))
		else $error("setpoint beyond saturation bound");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> falls_q >= FallNeed)
		else $error("result before calibration finished");
endmodule

bind rc_steering_pulse_integrator rcsp_chk #(.CAL_PULSES(CAL_PULSES)) u_rcsp_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.cfg_we             (cfg_we),
	.cfg_idx            (cfg_idx),
	.cfg_data           (cfg_data),
	.evt_valid          (evt.valid),
	.evt_ready          (evt.ready),
	.evt_edge_high      (evt.edge_high),
	.evt_auto_mode      (evt.auto_mode),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_steer_setpoint (res.steer_setpoint)
);

/* sim/tb_rc_steering_pulse_integrator.sv */
// tb_rc_steering_pulse_integrator: self-checking bench for the rc steering pulse integrator.
// Uses rcsp_pkg, rcsp_in_if and rcsp_out_if from the rtl. Random valid/ready on both sides,
// with a behavioral copy of the integrator that predicts every setpoint beat.
`timescale 1ns / 1ps

module tb_rc_steering_pulse_integrator;
	import rcsp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam longint CAL_N = CAL_PULSES_DEF;
	localparam longint TPS = TICKS_PER_STEP_DEF;
	localparam int SETTLE_CYCLES = 48;

	typedef struct packed {
		logic               edge_high;
		logic [STAMP_W-1:0] stamp;
		logic               auto_mode;
	} cap_evt_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	rcsp_in_if  evt_if ();
	rcsp_out_if res_if ();

	rc_steering_pulse_integrator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.evt      (evt_if),
		.res      (res_if)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// integrator copy
	longint             limit_cfg, deadband_cfg, window_cfg;
	logic [STAMP_W-1:0] rise_mark;
	bit                 skip_first_fall;
	longint             cal_count;
	longint             centre_acc;
	longint             setpoint_acc;

	cap_evt_t               pending_events[$];
	logic signed [SP_W-1:0] expected_setpoints[$];
	cap_evt_t               next_evt, seen_evt;
	logic signed [SP_W-1:0] want_sp;

	bit no_idle;
	int errors, events_taken, beats_checked, settings_used;

	function automatic bit take_gap();
		return !no_idle && ($urandom_range(0, 99) < 25);
	endfunction

	task automatic integrate_event(input cap_evt_t e);
		logic [STAMP_W-1:0] diff;
		longint width, offset, step, nxt;
		if (e.auto_mode)
			return;
		if (e.edge_high) begin
			rise_mark = e.stamp;
			return;
		end
		if (skip_first_fall) begin
			skip_first_fall = 1'b0;
			return;
		end
		diff = e.stamp - rise_mark;
		width = $signed(diff);
		if (cal_count < CAL_N) begin
			centre_acc += width;
			cal_count++;
			if (cal_count == CAL_N)
				centre_acc = centre_acc / CAL_N;
			return;
		end
		offset = width - centre_acc;
		if (offset > window_cfg || offset < -window_cfg)
			return;
		if (offset > deadband_cfg)
			step = (offset - deadband_cfg) / TPS;
		else if (offset < -deadband_cfg)
			step = (offset + deadband_cfg) / TPS;
		else
			return;
		nxt = setpoint_acc + step;
		if (nxt > limit_cfg)
			nxt = limit_cfg;
		if (nxt < -limit_cfg)
			nxt = -limit_cfg;
		setpoint_acc = nxt;
		expected_setpoints.push_back(setpoint_acc[SP_W-1:0]);
	endtask

	// event driver
	always @(posedge clk) begin
		if (!arst_n) begin
			evt_if.valid <= 1'b0;
		end else begin
			if (evt_if.valid && evt_if.ready) begin
				seen_evt = {evt_if.edge_high, evt_if.stamp, evt_if.auto_mode};
				integrate_event(seen_evt);
				events_taken++;
			end
			if (!evt_if.valid || evt_if.ready) begin
				if (pending_events.size() != 0 && !take_gap()) begin
					next_evt = pending_events.pop_front();
					evt_if.valid <= 1'b1;
					evt_if.edge_high <= next_evt.edge_high;
					evt_if.stamp <= next_evt.stamp;
					evt_if.auto_mode <= next_evt.auto_mode;
				end else begin
					evt_if.valid <= 1'b0;
				end
			end
		end
	end

	// setpoint monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (expected_setpoints.size() == 0) begin
					errors++;
					$display("%0t: unexpected setpoint beat, expected none, actual %0d",
						$time, res_if.steer_setpoint);
				end else begin
					want_sp = expected_setpoints.pop_front();
					if (res_if.steer_setpoint !== want_sp) begin
						errors++;
						$display("%0t: steer_setpoint mismatch, expected %0d, actual %0d",
							$time, want_sp, res_if.steer_setpoint);
					end
				end
				beats_checked++;
			end
			res_if.ready <= !take_gap();
		end
	end

	task automatic queue_event(input logic edge_high, input logic [STAMP_W-1:0] stamp,
		input logic auto_mode);
		cap_evt_t e;
		e.edge_high = edge_high;
		e.stamp = stamp;
		e.auto_mode = auto_mode;
		pending_events.push_back(e);
	endtask

	task automatic queue_pulse(input logic [STAMP_W-1:0] rise, input longint width);
		logic [STAMP_W-1:0] w;
		w = width[STAMP_W-1:0];
		queue_event(1'b1, rise, 1'b0);
		queue_event(1'b0, rise + w, 1'b0);
	endtask

	// offset from centre, biased toward the deadband and window boundaries
	function automatic longint pick_offset();
		longint mag;
		bit neg;
		neg = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: mag = deadband_cfg;
			1: mag = deadband_cfg + 1;
			2: mag = window_cfg;
			3: mag = window_cfg + 1;
			4: mag = longint'($urandom_range(0, 32'(deadband_cfg)));
			5, 6, 7: begin
				if (window_cfg > deadband_cfg)
					mag = longint'($urandom_range(32'(deadband_cfg + 1), 32'(window_cfg)));
				else
					mag = deadband_cfg + 1;
			end
			8: mag = window_cfg + 1 + longint'($urandom_range(0, 32'h3FFF_FFFF));
			default: mag = longint'($urandom_range(0, 32'h7FFF_FFFF));
		endcase
		return neg ? -mag : mag;
	endfunction

	task automatic queue_noise();
		case ($urandom_range(0, 3))
			0: queue_event(1'($urandom_range(0, 1)), $urandom, 1'b1);
			1: queue_event(1'b1, $urandom, 1'b0);
			// fall against a stale rise stamp
			2: queue_event(1'b0, $urandom, 1'b0);
			default: queue_event(1'($urandom_range(0, 1)), $urandom,
				1'($urandom_range(0, 1)));
		endcase
	endtask

	task automatic run_pulses(input int count);
		@(negedge clk);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 12)
				queue_noise();
			queue_pulse($urandom, centre_acc + pick_offset());
		end
	endtask

	task automatic wait_quiet();
		while (pending_events.size() != 0 || evt_if.valid || expected_setpoints.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SETPOINT_LIMIT: limit_cfg = longint'(data[LIM_W-1:0]);
			REG_DEADBAND_TICKS: deadband_cfg = longint'(data[DB_W-1:0]);
			REG_WINDOW_TICKS:   window_cfg = longint'(data[WIN_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [LIM_W-1:0] lim, input logic [DB_W-1:0] db,
		input logic [WIN_W-1:0] win);
		write_reg(REG_SETPOINT_LIMIT, lim);
		// upper data bits are junk for the 16-bit deadband
		write_reg(REG_DEADBAND_TICKS, {4'($urandom_range(0, 15)), db});
		write_reg(REG_WINDOW_TICKS, win);
		write_reg(REG_UNUSED, 20'($urandom));
		settings_used++;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		evt_if.valid = 1'b0;
		evt_if.edge_high = 1'b0;
		evt_if.stamp = '0;
		evt_if.auto_mode = 1'b0;
		res_if.ready = 1'b0;
		limit_cfg = longint'(LIMIT_RST);
		deadband_cfg = longint'(DEADBAND_RST);
		window_cfg = longint'(WINDOW_RST);
		rise_mark = '0;
		skip_first_fall = 1'b1;
		cal_count = 0;
		centre_acc = 0;
		setpoint_acc = 0;
		no_idle = 1'b0;
		errors = 0;
		events_taken = 0;
		beats_checked = 0;
		settings_used = 1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// power-up sequence and calibration at reset settings
		queue_event(1'b0, '1, 1'b1);
		queue_event(1'b1, 32'h1234_5678, 1'b1);
		queue_event(1'b0, '0, 1'b0);
		queue_event(1'b0, 32'd30000, 1'b0);
		queue_pulse('1, longint'(30010));
		queue_pulse(32'hFFFF_8000, longint'(29995));
		queue_pulse(32'h0000_0001, longint'(-20));
		for (int i = 0; i < 6; i++)
			queue_pulse($urandom, longint'(29990 + $urandom_range(0, 40)));
		wait_quiet();

		@(negedge clk);
		queue_pulse($urandom, centre_acc + deadband_cfg);
		queue_pulse($urandom, centre_acc + deadband_cfg + 1);
		queue_pulse($urandom, centre_acc - window_cfg);
		wait_quiet();

		// two random batches, each drained until the result side is empty
		run_pulses(30);
		wait_quiet();
		run_pulses(30);
		wait_quiet();

		apply_config('1, '0, '1);
		no_idle = 1'b1;
		run_pulses(50);
		wait_quiet();
		no_idle = 1'b0;

		// zero limit pulls any running setpoint back to zero
		apply_config('0, '1, '1);
		run_pulses(20);
		wait_quiet();

		apply_config(20'd300, 16'd100, 20'd20000);
		run_pulses(50);
		wait_quiet();

		apply_config(20'd777, '0, '0);
		run_pulses(10);
		wait_quiet();

		repeat (3) begin
			apply_config(LIM_W'($urandom_range(0, 20'hFFFFF) >> $urandom_range(0, 12)),
				DB_W'($urandom), WIN_W'($urandom_range(0, 20'hFFFFF) >> $urandom_range(0, 6)));
			run_pulses(40);
			wait_quiet();
		end

		$display("covered %0d capture events over %0d register settings", events_taken,
			settings_used);
		$display("checked %0d setpoint beats, %0d mismatches", beats_checked, errors);
		if (errors == 0 && expected_setpoints.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/rcsp_pkg.sv
rtl/core/rcsp_in_if.sv
rtl/core/rcsp_out_if.sv
rtl/core/rcsp_cdiv.sv
rtl/core/rcsp_front.sv
rtl/core/rcsp_step.sv
rtl/core/rcsp_integ.sv
rtl/core/rc_steering_pulse_integrator.sv
rtl/core/rcsp_chk.sv
sim/tb_rc_steering_pulse_integrator.sv
